FILE: sv/greedy_nearest_point_tour_core_macros.svh
// Assertion macros shared by the tour core.
// No dependencies; the using file supplies clk and rst_n.
`ifndef GREEDY_NEAREST_POINT_TOUR_CORE_MACROS_SVH
`define GREEDY_NEAREST_POINT_TOUR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define GNPT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tour core check failed");

// Next-cycle implication, checked outside reset
`define GNPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tour core check failed");

`endif

FILE: sv/gnpt_pkg.sv
// Constants, register indexes and helpers for the greedy nearest-point tour core.
// No dependencies.
package gnpt_pkg;

    // Point store capacity
    localparam int MAX_POINTS = 32;
    localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Field widths
    localparam int X_W    = 29;
    localparam int Y_W    = 28;
    localparam int PT_W   = X_W + Y_W;
    localparam int IDX_W  = 6;
    localparam int DIST_W = 58;
    localparam int SUM_W  = DIST_W + 1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 1'b1;

    // Reset origin, millionths of a degree
    localparam logic signed [X_W-1:0] ORIGIN_X_RST = 29'sd120056144;
    localparam logic signed [Y_W-1:0] ORIGIN_Y_RST = 28'sd30281064;

    // Clamp the exact squared distance to the result field
    function automatic logic [DIST_W-1:0] sat_dist(input logic [SUM_W-1:0] d);
        logic [DIST_W-1:0] r;
        r = d[SUM_W-1] ? {DIST_W{1'b1}} : d[DIST_W-1:0];
        return r;
    endfunction

endpackage

FILE: sv/greedy_nearest_point_tour_core.sv
// Greedy nearest-point tour core: point memory, distance pipeline and tour sequencer.
// Depends on gnpt_pkg and greedy_nearest_point_tour_core_macros.svh.
//
// Points are loaded one per cycle into a point memory (up to 32; extras are
// dropped). The beat carrying last_point starts the tour, and no input is taken
// until the last visit has been handed to the output register. Each visit
// streams all N stored points out of the memory, one read per cycle, through a
// distance pipeline (read, difference, magnitude, square, sum and compare),
// then emits the winner once the output register is free. The single memory
// read port means every visit reads each stored point in turn. Ties go to the
// lowest index.
`include "greedy_nearest_point_tour_core_macros.svh"

module greedy_nearest_point_tour_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [gnpt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gnpt_pkg::X_W-1:0]            cfg_data,
    // Point input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [gnpt_pkg::X_W-1:0]     point_x,
    input  logic signed [gnpt_pkg::Y_W-1:0]     point_y,
    input  logic                                last_point,
    // Visit result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [gnpt_pkg::IDX_W-1:0]          visit_index,
    output logic [gnpt_pkg::DIST_W-1:0]         dist_squared,
    output logic                                last_of_run
);

    localparam int X_W    = gnpt_pkg::X_W;
    localparam int Y_W    = gnpt_pkg::Y_W;
    localparam int PT_W   = gnpt_pkg::PT_W;
    localparam int ADDR_W = gnpt_pkg::ADDR_W;
    localparam int CNT_W  = gnpt_pkg::CNT_W;
    localparam int MAXP   = gnpt_pkg::MAX_POINTS;
    localparam int SUM_W  = gnpt_pkg::SUM_W;

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;

    logic signed [X_W-1:0]  origin_x_reg;
    logic signed [Y_W-1:0]  origin_y_reg;
    logic signed [X_W-1:0]  cur_x_reg;
    logic signed [Y_W-1:0]  cur_y_reg;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       step_reg;
    logic [CNT_W-1:0]       scan_reg;
    logic [MAXP-1:0]        visited_reg;

    // Point memory
    logic [PT_W-1:0]        mem [MAXP];
    logic [PT_W-1:0]        rd_data_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [ADDR_W-1:0]      mem_raddr;

    // Distance pipeline
    logic                   p0_vld_reg;
    logic [ADDR_W-1:0]      p0_idx_reg;
    logic                   p1_vld_reg;
    logic [ADDR_W-1:0]      p1_idx_reg;
    logic [PT_W-1:0]        p1_pt_reg;
    logic signed [X_W:0]    p1_dx_reg;
    logic signed [Y_W:0]    p1_dy_reg;
    logic                   p2_vld_reg;
    logic [ADDR_W-1:0]      p2_idx_reg;
    logic [PT_W-1:0]        p2_pt_reg;
    logic [X_W-1:0]         p2_ax_reg;
    logic [Y_W-1:0]         p2_ay_reg;
    logic                   p3_vld_reg;
    logic [ADDR_W-1:0]      p3_idx_reg;
    logic [PT_W-1:0]        p3_pt_reg;
    logic [2*X_W-1:0]       p3_sx_reg;
    logic [2*Y_W-1:0]       p3_sy_reg;

    // Running best
    logic                   found_reg;
    logic [ADDR_W-1:0]      best_idx_reg;
    logic [SUM_W-1:0]       best_d_reg;
    logic [PT_W-1:0]        best_pt_reg;

    // Output register
    logic                           out_vld_reg;
    logic [gnpt_pkg::IDX_W-1:0]     visit_index_reg;
    logic [gnpt_pkg::DIST_W-1:0]    dist_reg;
    logic                           last_reg;

    logic                   in_acc;
    logic                   room;
    logic                   issue;
    logic                   last_issue;
    logic                   pipe_empty;
    logic                   out_free;
    logic                   emit;
    logic                   tour_last;
    logic [CNT_W-1:0]       count_inc;
    logic signed [X_W-1:0]  rd_x;
    logic signed [Y_W-1:0]  rd_y;
    logic signed [X_W:0]    dx;
    logic signed [Y_W:0]    dy;
    logic [X_W:0]           dx_abs;
    logic [Y_W:0]           dy_abs;
    logic [SUM_W-1:0]       sum;

    // Handshake and control terms
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_acc     = in_valid && (state_reg == ST_IDLE);
    assign room       = (count_reg < CNT_W'(MAXP));
    assign count_inc  = count_reg + CNT_W'(1);
    assign issue      = (state_reg == ST_SCAN);
    assign last_issue = issue && (scan_reg == count_reg - CNT_W'(1));
    assign pipe_empty = !(p0_vld_reg || p1_vld_reg || p2_vld_reg || p3_vld_reg);
    assign out_free   = !out_vld_reg || !out_stall;
    assign emit       = (state_reg == ST_EMIT) && out_free;
    assign tour_last  = (step_reg == count_reg - CNT_W'(1));

    assign mem_we     = in_acc && room;
    assign mem_waddr  = count_reg[ADDR_W-1:0];
    assign mem_raddr  = scan_reg[ADDR_W-1:0];

    // Point memory: one write port for loading, one read port for scans
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= {point_x, point_y};
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Next sequencer state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && last_point)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    state_next = tour_last ? ST_IDLE : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer, counters, visited flags, position and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            origin_x_reg <= gnpt_pkg::ORIGIN_X_RST;
            origin_y_reg <= gnpt_pkg::ORIGIN_Y_RST;
            cur_x_reg    <= gnpt_pkg::ORIGIN_X_RST;
            cur_y_reg    <= gnpt_pkg::ORIGIN_Y_RST;
            count_reg    <= '0;
            step_reg     <= '0;
            scan_reg     <= '0;
            visited_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Take configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gnpt_pkg::CFG_ORIGIN_X: origin_x_reg <= cfg_data[X_W-1:0];
                    gnpt_pkg::CFG_ORIGIN_Y: origin_y_reg <= cfg_data[Y_W-1:0];
                    default: ;
                endcase
            end

            // Load a point; start the tour from the origin on the last beat
            if (in_acc)
            begin
                if (room)
                begin
                    count_reg <= count_inc;
                end
                if (last_point)
                begin
                    step_reg    <= '0;
                    scan_reg    <= '0;
                    visited_reg <= '0;
                    cur_x_reg   <= origin_x_reg;
                    cur_y_reg   <= origin_y_reg;
                end
            end

            // Advance the scan address
            if (issue && !last_issue)
            begin
                scan_reg <= scan_reg + CNT_W'(1);
            end

            // Move to the chosen point; close the tour on its last visit
            if (emit)
            begin
                scan_reg <= '0;
                if (tour_last)
                begin
                    count_reg   <= '0;
                    step_reg    <= '0;
                    visited_reg <= '0;
                    cur_x_reg   <= origin_x_reg;
                    cur_y_reg   <= origin_y_reg;
                end
                else
                begin
                    visited_reg[best_idx_reg] <= 1'b1;
                    step_reg  <= step_reg + CNT_W'(1);
                    cur_x_reg <= best_pt_reg[PT_W-1 -: X_W];
                    cur_y_reg <= best_pt_reg[Y_W-1:0];
                end
            end
        end
    end

    // Stage valids, the found flag and the output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_vld_reg  <= 1'b0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
            found_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            p0_vld_reg <= issue && !visited_reg[mem_raddr];
            p1_vld_reg <= p0_vld_reg;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            if (emit)
            begin
                found_reg <= 1'b0;
            end
            else if (p3_vld_reg)
            begin
                found_reg <= 1'b1;
            end
            if (emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Difference, magnitude and sum terms
    always_comb
    begin
        rd_x   = rd_data_reg[PT_W-1 -: X_W];
        rd_y   = rd_data_reg[Y_W-1:0];
        dx     = {rd_x[X_W-1], rd_x} - {cur_x_reg[X_W-1], cur_x_reg};
        dy     = {rd_y[Y_W-1], rd_y} - {cur_y_reg[Y_W-1], cur_y_reg};
        dx_abs = p1_dx_reg[X_W] ? (X_W+1)'(-p1_dx_reg) : p1_dx_reg;
        dy_abs = p1_dy_reg[Y_W] ? (Y_W+1)'(-p1_dy_reg) : p1_dy_reg;
        sum    = {1'b0, p3_sx_reg} + SUM_W'(p3_sy_reg);
    end

    // Distance pipeline data
    always_ff @(posedge clk)
    begin
        // Hold the index beside the memory read
        p0_idx_reg <= mem_raddr;

        // Subtract the current position
        p1_idx_reg <= p0_idx_reg;
        p1_pt_reg  <= rd_data_reg;
        p1_dx_reg  <= dx;
        p1_dy_reg  <= dy;

        // Take magnitudes
        p2_idx_reg <= p1_idx_reg;
        p2_pt_reg  <= p1_pt_reg;
        p2_ax_reg  <= dx_abs[X_W-1:0];
        p2_ay_reg  <= dy_abs[Y_W-1:0];

        // Square each axis
        p3_idx_reg <= p2_idx_reg;
        p3_pt_reg  <= p2_pt_reg;
        p3_sx_reg  <= p2_ax_reg * p2_ax_reg;
        p3_sy_reg  <= p2_ay_reg * p2_ay_reg;

        // Keep the strictly nearer candidate; lowest index wins a tie
        if (p3_vld_reg && (!found_reg || (sum < best_d_reg)))
        begin
            best_idx_reg <= p3_idx_reg;
            best_d_reg   <= sum;
            best_pt_reg  <= p3_pt_reg;
        end

        // Load the result beat
        if (emit)
        begin
            visit_index_reg <= gnpt_pkg::IDX_W'(best_idx_reg);
            dist_reg        <= gnpt_pkg::sat_dist(best_d_reg);
            last_reg        <= tour_last;
        end
    end

    assign out_valid    = out_vld_reg;
    assign visit_index  = visit_index_reg;
    assign dist_squared = dist_reg;
    assign last_of_run  = last_reg;

    // Checks on sequencing
    `GNPT_ASSERT_SAME(a_scan_nonempty, state_reg == ST_SCAN, count_reg != '0)
    `GNPT_ASSERT_SAME(a_emit_found, state_reg == ST_EMIT, found_reg)
    `GNPT_ASSERT_SAME(a_emit_unvisited, emit, !visited_reg[best_idx_reg])
    `GNPT_ASSERT_SAME(a_pipe_in_tour, p3_vld_reg, state_reg == ST_SCAN || state_reg == ST_DRAIN)
    `GNPT_ASSERT_NEXT(a_tour_clears, emit && tour_last, count_reg == '0 && visited_reg == '0)

endmodule
